/* hw/rtl/fdp_pkg.sv */
// ----------------------------------------------------------------------------
// fdp_pkg
// Shared types and constants for the frame difference 12-bit pixel packer.
// ----------------------------------------------------------------------------
`default_nettype none

package fdp_pkg;

   // field widths
   localparam int PIX_W  = 16;
   localparam int V12_W  = 12;
   localparam int BYTE_W = 8;
   localparam int CSR_W  = 17;

   // default frame store depth
   localparam int MAX_PIXELS_DEF = 65536;

   // frame_pixels after reset
   localparam logic [CSR_W-1:0] FRAME_PIXELS_RST = 17'h10000;

   // frame mode codes
   localparam logic [1:0] FUNC_NORMAL = 2'd0;
   localparam logic [1:0] FUNC_KEY    = 2'd1;
   localparam logic [1:0] FUNC_DIFF   = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_FRAME_PIXELS    = 2'd0;
   localparam logic [1:0] CSR_BASE_PREV_FRAME = 2'd1;
   localparam logic [1:0] CSR_INPUT_IS_12BIT  = 2'd2;

   // input beat
   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic [1:0]       func;
   } req_type;

   // output beat
   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              run_last;
      logic              frame_last;
   } rsp_type;

   // one or two bytes handed to the output buffer
   typedef struct packed {
      logic    en;
      logic    two;
      rsp_type b0;
      rsp_type b1;
   } obuf_push_type;

endpackage

`default_nettype wire

/* hw/rtl/fdp_frame_store.sv */
// ----------------------------------------------------------------------------
// fdp_frame_store
// Reference frame memory, one read and one write port, registered read
// data. Runs a zero fill over every entry after reset and flags busy.
// ----------------------------------------------------------------------------
`default_nettype none

module fdp_frame_store #(
   parameter int MAX_PIXELS = fdp_pkg::MAX_PIXELS_DEF,
   parameter int AW         = $clog2(MAX_PIXELS)
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     rd_en,
   input  wire logic [AW-1:0]            rd_addr,
   output      logic [fdp_pkg::PIX_W-1:0] rd_data,
   input  wire logic                     wr_en,
   input  wire logic [AW-1:0]            wr_addr,
   input  wire logic [fdp_pkg::PIX_W-1:0] wr_data,
   output      logic                     busy
);
   import fdp_pkg::*;

   localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_PIXELS - 1);

   logic [PIX_W-1:0] mem [MAX_PIXELS];
   logic [PIX_W-1:0] rd_data_ff;
   logic             clr_active_ff, clr_active_in;
   logic [AW-1:0]    clr_addr_ff, clr_addr_in;

   // zero fill sequencer
   always_comb begin
      clr_active_in = clr_active_ff;
      clr_addr_in   = clr_addr_ff;
      if (clr_active_ff) begin
         clr_addr_in = clr_addr_ff + AW'(1);
         if (clr_addr_ff == LAST_ADDR) begin
            clr_active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_addr_ff   <= clr_addr_in;
      end
   end

   // memory write: fill has the port during the pass
   always_ff @(posedge clock) begin
      if (clr_active_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // memory read, registered output
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = clr_active_ff;

endmodule

`default_nettype wire

/* hw/rtl/fdp_obuf.sv */
// ----------------------------------------------------------------------------
// fdp_obuf
// Two-slot output byte buffer. Takes one or two bytes per push, sends one
// beat per cycle when not stalled, reports room left after this cycle's pop.
// ----------------------------------------------------------------------------
`default_nettype none

module fdp_obuf (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire fdp_pkg::obuf_push_type push,
   output      logic [1:0]             room,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   output      fdp_pkg::rsp_type       rsp_data
);
   import fdp_pkg::*;

   rsp_type    q_ff [2];
   rsp_type    q_in [2];
   logic [1:0] cnt_ff, cnt_in;
   logic [1:0] cnt_mid;
   logic       pop;

   assign pop     = (cnt_ff != 2'd0) && !rsp_stall;
   assign cnt_mid = cnt_ff - {1'b0, pop};
   assign room    = 2'd2 - cnt_mid;

   // shift out the head, then append behind what is left
   always_comb begin
      q_in[0] = q_ff[0];
      q_in[1] = q_ff[1];
      cnt_in  = cnt_mid;
      if (pop) begin
         q_in[0] = q_ff[1];
      end
      if (push.en) begin
         q_in[cnt_mid[0]] = push.b0;
         if (push.two) begin
            q_in[1] = push.b1;
         end
         cnt_in = cnt_mid + 2'd1 + {1'b0, push.two};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff[0] <= q_in[0];
      q_ff[1] <= q_in[1];
   end

   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_data  = q_ff[0];

endmodule

`default_nettype wire

/* hw/rtl/frame_diff_12bit_pixel_packer.sv */
// ----------------------------------------------------------------------------
// frame_diff_12bit_pixel_packer
// Interframe difference (in diff mode) against a stored reference frame,
// reduction to 12 bits and packing of pixel pairs into three bytes.
//
//   channel | dir | beat
//   --------+-----+-------------------------------------------
//   req     | in  | req_type: pixel, func
//   rsp     | out | rsp_type: out_byte, run_last, frame_last
//   csr     | in  | csr_index, csr_wdata on csr_we
//
// A pixel is accepted as the store is read at its index, waits in the
// store-read stage for buffer room, then pushes its byte(s) into a two-slot
// output buffer. rsp sends one byte per cycle while rsp_stall is low.
// After reset the store is zero filled and req_stall is high until the
// fill ends; csr writes are taken during that time.
// rsp_stall backs up through the buffer into req_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_diff_12bit_pixel_packer #(
   parameter int MAX_PIXELS = fdp_pkg::MAX_PIXELS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output      logic                      req_stall,
   input  wire fdp_pkg::req_type          req_data,
   output      logic                      rsp_valid,
   input  wire logic                      rsp_stall,
   output      fdp_pkg::rsp_type          rsp_data,
   input  wire logic                      csr_we,
   input  wire logic [1:0]                csr_index,
   input  wire logic [fdp_pkg::CSR_W-1:0] csr_wdata
);
   import fdp_pkg::*;

   localparam int AW = $clog2(MAX_PIXELS);
   localparam int SW = (AW + 1 > CSR_W) ? AW + 1 : CSR_W;
   localparam logic [SW-1:0] MAX_SIZE = SW'(MAX_PIXELS);
   localparam logic [SW-1:0] MIN_SIZE = SW'(2);

   // configuration
   logic [CSR_W-1:0] frame_pixels_ff;
   logic             base_prev_ff;
   logic             is_12bit_ff;

   // frame position
   logic [AW-1:0] pixel_index_ff, pixel_index_in;
   logic          phase_ff, phase_in;

   // store-read stage
   logic             s1_v_ff, s1_v_in;
   logic [PIX_W-1:0] s1_pix_ff;
   logic [1:0]       s1_func_ff;
   logic [AW-1:0]    s1_idx_ff;
   logic             s1_last_ff;
   logic             s1_phase_ff;
   logic [3:0]       pending_ff, pending_in;

   logic             accept, adv, busy, last;
   logic [SW-1:0]    size, fp, idx_next;
   logic [PIX_W-1:0] rd_data, val;
   logic [V12_W-1:0] v12;
   logic [1:0]       room;
   logic             st_wr;
   obuf_push_type    push;

   // config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_pixels_ff <= FRAME_PIXELS_RST;
         base_prev_ff    <= 1'b0;
         is_12bit_ff     <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FRAME_PIXELS:    frame_pixels_ff <= csr_wdata;
            CSR_BASE_PREV_FRAME: base_prev_ff    <= csr_wdata[0];
            CSR_INPUT_IS_12BIT:  is_12bit_ff     <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // clamped frame size and end-of-frame test
   always_comb begin
      fp = SW'(frame_pixels_ff);
      if (fp < MIN_SIZE) begin
         size = MIN_SIZE;
      end else if (fp > MAX_SIZE) begin
         size = MAX_SIZE;
      end else begin
         size = fp;
      end
      idx_next = SW'(pixel_index_ff) + SW'(1);
      last     = (idx_next >= size);
   end

   // handshake
   assign adv       = s1_v_ff && !busy && (room >= (s1_phase_ff ? 2'd2 : 2'd1));
   assign req_stall = busy || (s1_v_ff && !adv);
   assign accept    = req_valid && !req_stall;

   // position tracking at accept
   always_comb begin
      pixel_index_in = pixel_index_ff;
      phase_in       = phase_ff;
      s1_v_in        = s1_v_ff;
      if (adv) begin
         s1_v_in = 1'b0;
      end
      if (accept) begin
         s1_v_in = 1'b1;
         if (last) begin
            pixel_index_in = '0;
            phase_in       = 1'b0;
         end else begin
            pixel_index_in = idx_next[AW-1:0];
            phase_in       = !phase_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_index_ff <= '0;
         phase_ff       <= 1'b0;
         s1_v_ff        <= 1'b0;
         pending_ff     <= '0;
      end else begin
         pixel_index_ff <= pixel_index_in;
         phase_ff       <= phase_in;
         s1_v_ff        <= s1_v_in;
         pending_ff     <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff   <= req_data.pixel;
         s1_func_ff  <= req_data.func;
         s1_idx_ff   <= pixel_index_ff;
         s1_last_ff  <= last;
         s1_phase_ff <= phase_ff;
      end
   end

   // difference, reduction, store update
   always_comb begin
      val = (s1_func_ff == FUNC_DIFF) ? (s1_pix_ff - rd_data) : s1_pix_ff;
      v12 = is_12bit_ff ? val[V12_W-1:0] : val[PIX_W-1:4];
      st_wr = adv && ((s1_func_ff == FUNC_KEY) || base_prev_ff);
   end

   // byte packing
   always_comb begin
      push.en    = adv;
      push.two   = s1_phase_ff;
      pending_in = pending_ff;
      if (s1_phase_ff) begin
         push.b0 = '{out_byte: {pending_ff, v12[11:8]}, run_last: 1'b0,
                     frame_last: 1'b0};
         push.b1 = '{out_byte: v12[7:0], run_last: 1'b1, frame_last: s1_last_ff};
      end else begin
         push.b0 = '{out_byte: v12[11:4], run_last: 1'b1, frame_last: s1_last_ff};
         push.b1 = push.b0;
      end
      if (adv) begin
         pending_in = s1_phase_ff ? 4'd0 : v12[3:0];
      end
   end

   fdp_frame_store #(
      .MAX_PIXELS (MAX_PIXELS),
      .AW         (AW)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (pixel_index_ff),
      .rd_data (rd_data),
      .wr_en   (st_wr),
      .wr_addr (s1_idx_ff),
      .wr_data (s1_pix_ff),
      .busy    (busy)
   );

   fdp_obuf u_obuf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

/* hw/rtl/fdp_checker.sv */
// ----------------------------------------------------------------------------
// fdp_checker
// Port-level checks for the frame difference pixel packer, bound to the
// top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fdp_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_stall,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire fdp_pkg::rsp_type rsp_data
);

   // store fill holds off input right after reset
   a_fill_after_reset: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("req not stalled after reset");

   // a pixel's first byte of a pair is never its frame end
   a_frame_last_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.run_last |-> !rsp_data.frame_last)
      else $error("frame_last on a non-final byte");

   // second byte of a pair is already buffered
   a_pair_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.run_last |=> rsp_valid)
      else $error("gap inside a pixel's bytes");

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat changed under stall");

endmodule

bind frame_diff_12bit_pixel_packer fdp_checker u_fdp_checker (.*);

`default_nettype wire
